@@ hw/rtl/fnpll_pkg.sv @@
package fnpll_pkg;

  localparam int FRACTION_BITS_DEF = 20;

  localparam logic [25:0] REF_HZ_RESET = 26'd20000000;

  localparam logic PADDR_REF_HZ  = 1'b0;
  localparam logic PADDR_REF_DIV = 1'b1;

  localparam logic [7:0] INT_MIN_DIV = 8'd64;
  localparam logic [7:0] INT_MAX_DIV = 8'd255;

  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_LOW  = 2'd1;
  localparam logic [1:0] CLAMP_HIGH = 2'd2;

  localparam logic [3:0] FRAME_ADDR_LOW  = 4'd3;
  localparam logic [3:0] FRAME_ADDR_HIGH = 4'd4;

endpackage

@@ hw/rtl/frac_n_pll_divider_calc.sv @@
// Fractional-N divider calculator. A target frequency is taken whenever start is high;
// busy stays low, so an item can be issued every cycle. Each item passes through a
// pipeline of 40 + FRACTION_BITS register stages (32 for the integer divide, FRACTION_BITS
// for the fraction divide, four folding stages and one correction stage for the divide of
// the achieved frequency by 2^FRACTION_BITS - 1, plus three arithmetic stages) and its
// results appear with done for one cycle, in issue order. The receiver cannot stall the
// pipeline. Reference settings are captured per item at issue.
module frac_n_pll_divider_calc
  import fnpll_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] target_hz,
  output logic        done,
  output logic [7:0]  integer_divider,
  output logic [19:0] fractional_divider,
  output logic [17:0] low_frame,
  output logic [17:0] high_frame,
  output logic [33:0] achieved_hz,
  output logic [1:0]  clamp_status
);

  localparam int F       = FRACTION_BITS;
  localparam int NFOLD   = 4;
  localparam int S_B0    = 32;
  localparam int S_C0    = 33 + F;
  localparam int S_E     = S_C0 + NFOLD + 1;
  localparam int S_D     = S_E + 1;
  localparam int NS      = S_D + 1;
  localparam logic [F+25:0] FULL_W = (F+26)'((64'd1 << F) - 64'd1);

  typedef struct packed {
    logic          v;
    logic          zero;
    logic [25:0]   comp;
    logic [25:0]   div;
    logic [31:0]   num;
    logic [25:0]   rem;
    logic [31:0]   quo;
    logic [7:0]    intd;
    logic [1:0]    st;
    logic [F-1:0]  frac;
    logic [F+25:0] acc;
    logic [33:0]   ach;
  } pipe_t;

  logic [25:0] reference_hz;
  logic        ref_divide_by_two;
  pipe_t       pipe [NS];
  pipe_t       nxt  [NS];
  pipe_t       init;
  logic [F+19:0] frac_ext;

  function automatic pipe_t div_step(pipe_t s);
    logic [26:0] t;
    logic        ge;
    pipe_t       o;
    o = s;
    t = {s.rem, s.num[31]};
    ge = t >= {1'b0, s.div};
    o.rem = ge ? 26'(t - {1'b0, s.div}) : t[25:0];
    o.num = {s.num[30:0], 1'b0};
    o.quo = {s.quo[30:0], ge};
    return o;
  endfunction

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_hz      <= REF_HZ_RESET;
      ref_divide_by_two <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == PADDR_REF_HZ) begin
        reference_hz <= pwdata[25:0];
      end else begin
        ref_divide_by_two <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == PADDR_REF_HZ) begin
      prdata = {6'd0, reference_hz};
    end else begin
      prdata = {31'd0, ref_divide_by_two};
    end
  end

  always_comb begin
    init = '0;
    init.v = start;
    init.comp = ref_divide_by_two ? {1'b0, reference_hz[25:1]} : reference_hz;
    init.zero = (init.comp == 26'd0);
    init.div = init.comp;
    init.num = target_hz;
  end

  genvar k;
  for (k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_comb nxt[k] = div_step(init);
    end else if (k == S_B0) begin : g_b0
      logic [F+25:0] dv2;
      always_comb begin
        nxt[k] = pipe[k-1];
        dv2 = {pipe[k-1].rem, {F{1'b0}}} - (F+26)'(pipe[k-1].rem);
        if (pipe[k-1].zero) begin
          nxt[k].intd = INT_MAX_DIV;
          nxt[k].st   = CLAMP_HIGH;
        end else if (pipe[k-1].quo < 32'(INT_MIN_DIV)) begin
          nxt[k].intd = INT_MIN_DIV;
          nxt[k].st   = CLAMP_LOW;
        end else if (pipe[k-1].quo > 32'(INT_MAX_DIV)) begin
          nxt[k].intd = INT_MAX_DIV;
          nxt[k].st   = CLAMP_HIGH;
        end else begin
          nxt[k].intd = pipe[k-1].quo[7:0];
          nxt[k].st   = CLAMP_NONE;
        end
        nxt[k].rem = dv2[F+25:F];
        nxt[k].num = {dv2[F-1:0], {(32-F){1'b0}}};
        nxt[k].quo = '0;
      end
    end else if (k == S_C0) begin : g_c0
      logic [F-1:0]  fr;
      always_comb begin
        nxt[k] = pipe[k-1];
        fr = pipe[k-1].zero ? '0 : pipe[k-1].quo[F-1:0];
        nxt[k].frac = fr;
        nxt[k].acc  = {26'd0, fr} * {{F{1'b0}}, pipe[k-1].comp};
        nxt[k].quo  = '0;
      end
    end else if (k > S_C0 && k < S_E) begin : g_fold
      always_comb begin
        nxt[k] = pipe[k-1];
        nxt[k].quo = pipe[k-1].quo + {6'd0, pipe[k-1].acc[F+25:F]};
        nxt[k].acc = {{F{1'b0}}, pipe[k-1].acc[F+25:F]} +
                     {26'd0, pipe[k-1].acc[F-1:0]};
      end
    end else if (k == S_E) begin : g_e
      always_comb begin
        nxt[k] = pipe[k-1];
        nxt[k].quo = pipe[k-1].quo + {31'd0, pipe[k-1].acc >= FULL_W};
      end
    end else if (k == S_D) begin : g_d
      logic [33:0] m;
      always_comb begin
        nxt[k] = pipe[k-1];
        m = {26'd0, pipe[k-1].intd} * {8'd0, pipe[k-1].comp};
        nxt[k].ach = m + {8'd0, pipe[k-1].quo[25:0]};
      end
    end else begin : g_div
      always_comb nxt[k] = div_step(pipe[k-1]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[k].v <= 1'b0;
      end else begin
        pipe[k].v <= nxt[k].v;
      end
    end

    always_ff @(posedge clk) begin
      pipe[k].zero <= nxt[k].zero;
      pipe[k].comp <= nxt[k].comp;
      pipe[k].div  <= nxt[k].div;
      pipe[k].num  <= nxt[k].num;
      pipe[k].rem  <= nxt[k].rem;
      pipe[k].quo  <= nxt[k].quo;
      pipe[k].intd <= nxt[k].intd;
      pipe[k].st   <= nxt[k].st;
      pipe[k].frac <= nxt[k].frac;
      pipe[k].acc  <= nxt[k].acc;
      pipe[k].ach  <= nxt[k].ach;
    end
  end

  assign frac_ext           = {20'd0, pipe[NS-1].frac};
  assign done               = pipe[NS-1].v;
  assign integer_divider    = pipe[NS-1].intd;
  assign fractional_divider = frac_ext[19:0];
  assign low_frame          = {frac_ext[5:0], pipe[NS-1].intd, FRAME_ADDR_LOW};
  assign high_frame         = {frac_ext[19:6], FRAME_ADDR_HIGH};
  assign achieved_hz        = pipe[NS-1].ach;
  assign clamp_status       = pipe[NS-1].st;

endmodule

@@ tb/sv/frac_n_pll_divider_calc_tb.sv @@
`timescale 1ns / 1ps

module frac_n_pll_divider_calc_tb;
  import fnpll_pkg::*;

  localparam logic [2:0] ADDR_REFERENCE = 3'd0;
  localparam logic [2:0] ADDR_HALVE     = 3'd4;
  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT  = 3000;
  localparam logic [63:0] FULL_SCALE = (64'd1 << FRACTION_BITS_DEF) - 64'd1;

  typedef struct {
    logic [7:0]  integer_div;
    logic [19:0] fraction;
    logic [17:0] frame_lo;
    logic [17:0] frame_hi;
    logic [33:0] achieved;
    logic [1:0]  status;
  } divider_settings_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [31:0] target_hz = '0;
  logic done;
  logic [7:0] integer_divider;
  logic [19:0] fractional_divider;
  logic [17:0] low_frame, high_frame;
  logic [33:0] achieved_hz;
  logic [1:0] clamp_status;

  logic [25:0] cur_reference = REF_HZ_RESET;
  logic cur_halve = 1'b0;
  bit allow_idle = 1'b1;
  int errors = 0;
  int stall_cycles = 0;
  divider_settings_t pending_settings[$];

  frac_n_pll_divider_calc dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .target_hz(target_hz), .done(done),
    .integer_divider(integer_divider), .fractional_divider(fractional_divider),
    .low_frame(low_frame), .high_frame(high_frame), .achieved_hz(achieved_hz),
    .clamp_status(clamp_status)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] comparison_hz();
    return cur_halve ? {39'd0, cur_reference[25:1]} : {38'd0, cur_reference};
  endfunction

  function automatic divider_settings_t compute_settings(logic [31:0] target);
    divider_settings_t s;
    logic [63:0] comp, quot, rem, intd, frac, ach, wlo, whi;
    comp = comparison_hz();
    frac = 0;
    ach = 0;
    if (comp == 0) begin
      intd = INT_MAX_DIV;
      s.status = CLAMP_HIGH;
    end else begin
      quot = {32'd0, target} / comp;
      rem = {32'd0, target} % comp;
      if (quot < INT_MIN_DIV) begin
        intd = INT_MIN_DIV;
        s.status = CLAMP_LOW;
      end else if (quot > INT_MAX_DIV) begin
        intd = INT_MAX_DIV;
        s.status = CLAMP_HIGH;
      end else begin
        intd = quot;
        s.status = CLAMP_NONE;
      end
      frac = (rem * FULL_SCALE) / comp;
      ach = intd * comp + (frac * comp) / FULL_SCALE;
    end
    wlo = (intd | ((frac & 64'h3F) << 8)) & 64'h3FFF;
    whi = (frac >> 6) & 64'h3FFF;
    s.integer_div = intd[7:0];
    s.fraction = frac[19:0];
    s.frame_lo = {wlo[13:0], FRAME_ADDR_LOW};
    s.frame_hi = {whi[13:0], FRAME_ADDR_HIGH};
    s.achieved = ach[33:0];
    return s;
  endfunction

  function automatic void check_field(string name, logic [63:0] expv, logic [63:0] actv);
    if (expv !== actv) begin
      errors++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, expv, actv);
    end
  endfunction

  always @(posedge clk) begin
    divider_settings_t e;
    if (!rst && done) begin
      if (pending_settings.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual integer %0d", $time,
                 integer_divider);
      end else begin
        e = pending_settings.pop_front();
        check_field("integer_divider", e.integer_div, integer_divider);
        check_field("fractional_divider", e.fraction, fractional_divider);
        check_field("low_frame", e.frame_lo, low_frame);
        check_field("high_frame", e.frame_hi, high_frame);
        check_field("achieved_hz", e.achieved, achieved_hz);
        check_field("clamp_status", e.status, clamp_status);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_target(logic [31:0] value);
    start <= 1'b1;
    target_hz <= value;
    do @(posedge clk); while (busy);
    pending_settings.push_back(compute_settings(value));
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic write_register(logic [2:0] addr, logic [31:0] value);
    start <= 1'b0;
    wait (pending_settings.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_REFERENCE) cur_reference = value[25:0];
    else cur_halve = value[0];
  endtask

  task automatic configure(logic [25:0] reference, logic halve);
    write_register(ADDR_REFERENCE, {6'd0, reference});
    write_register(ADDR_HALVE, {31'd0, halve});
  endtask

  function automatic logic [31:0] random_target();
    logic [63:0] comp, t;
    comp = comparison_hz();
    case ($urandom_range(0, 9))
      0, 1: t = $urandom;
      2: t = comp * $urandom_range(0, 63) + (comp == 0 ? 0 : $urandom_range(0, comp - 1));
      3: t = comp * $urandom_range(256, 400) + (comp == 0 ? 0 : $urandom_range(0, comp - 1));
      default: t = comp * $urandom_range(64, 255) +
                   (comp == 0 ? 0 : $urandom_range(0, comp - 1));
    endcase
    if (t > 64'hFFFF_FFFF) t = $urandom;
    return t[31:0];
  endfunction

  task automatic test_directed_edges();
    logic [31:0] edges[$];
    edges = {32'd0, 32'd1, 32'd1279999999, 32'd1280000000, 32'd1280000001,
             32'd2500000000, 32'd2512345678, 32'd4099999999,
             32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
             32'd2019999999, 32'd1300000001};
    foreach (edges[i]) send_target(edges[i]);
  endtask

  task automatic test_boundary_references();
    configure(26'h3FF_FFFF, 1'b0);
    send_target(32'hFFFF_FFFF);
    send_target(32'd4294967295 - 32'd1);
    send_target(32'h0400_0000 * 32'd64 - 32'd1);
    configure(26'd1000000, 1'b1);
    send_target(32'd32000000);
    send_target(32'd127999999);
    send_target(32'd128000000);
  endtask

  task automatic test_zero_comparison();
    configure(26'd0, 1'b0);
    send_target(32'd12345678);
    send_target(32'hFFFF_FFFF);
    configure(26'd1, 1'b1);
    send_target(32'd0);
    send_target(32'd987654321);
  endtask

  task automatic test_random_settings(logic [25:0] reference, logic halve, int count);
    configure(reference, halve);
    repeat (count) send_target(random_target());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_boundary_references();
    test_zero_comparison();
    test_random_settings(26'd40000000, 1'b0, 70);
    test_random_settings(26'd1000000, 1'b0, 70);
    test_random_settings(26'h3FF_FFFF, 1'b1, 70);
    test_random_settings(26'($urandom_range(1000000, 40000000)), 1'b1, 70);
    test_random_settings(26'($urandom_range(1000000, 40000000)), 1'b0, 70);
    test_random_settings(26'd3, 1'b1, 10);
    allow_idle = 1'b0;
    test_random_settings(26'd20000000, 1'b0, 70);
    start <= 1'b0;
    wait (pending_settings.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
